[sv/ctwl_pkg.sv]
`timescale 1ns / 1ps
package ctwl_pkg;

  localparam int HuW   = 13;
  localparam int DiffW = 12;
  localparam int NumW  = 22;
  localparam int GreyW = 8;

  localparam logic signed [HuW-1:0] HuMin    = -13'sd1024;
  localparam logic signed [HuW-1:0] HuMax    = 13'sd3071;
  localparam logic [HuW-1:0]        WidthMax = 13'd4095;
  localparam logic [GreyW-1:0]      GreyMax  = 8'd255;
  localparam logic [9:0]            TwiceMax = 10'd510;

  // configuration register indexes
  localparam logic [1:0] RegStart = 2'd0;
  localparam logic [1:0] RegWidth = 2'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAMPLE  = 2'd1,
    ST_START   = 2'd2,
    ST_WIDTH   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_FULL = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  // classified word handed from front to back
  typedef struct packed {
    status_t          status;
    kind_t            kind;
    logic [DiffW-1:0] diff;
    logic [DiffW-1:0] width;
  } item_t;

endpackage

[sv/ctwl_front.sv]
`timescale 1ns / 1ps
module ctwl_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [12:0]           in_hu_sample,
  input  logic signed [12:0]           start,
  input  logic [12:0]                  width,
  input  logic                         pop,
  output logic                         q_valid,
  output ctwl_pkg::item_t              q_item
);

  ctwl_pkg::item_t  cls;
  ctwl_pkg::item_t  mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             push;
  logic signed [14:0] top_edge;
  logic signed [13:0] diff_full;

  // classify the sample against the window
  always_comb begin
    top_edge  = 15'(start) + $signed({2'b00, width});
    diff_full = 14'(in_hu_sample) - 14'(start);
    cls.diff  = diff_full[11:0];
    cls.width = width[11:0];
    cls.status = ctwl_pkg::ST_OK;
    cls.kind   = ctwl_pkg::KIND_DIV;
    if (in_hu_sample < ctwl_pkg::HuMin || in_hu_sample > ctwl_pkg::HuMax) begin
      cls.status = ctwl_pkg::ST_SAMPLE;
      cls.kind   = ctwl_pkg::KIND_ZERO;
    end else if (start < ctwl_pkg::HuMin || start > ctwl_pkg::HuMax) begin
      cls.status = ctwl_pkg::ST_START;
      cls.kind   = ctwl_pkg::KIND_ZERO;
    end else if (width == '0 || width > ctwl_pkg::WidthMax) begin
      cls.status = ctwl_pkg::ST_WIDTH;
      cls.kind   = ctwl_pkg::KIND_ZERO;
    end else if (in_hu_sample < start) begin
      cls.kind = ctwl_pkg::KIND_ZERO;
    end else if (15'(in_hu_sample) > top_edge) begin
      cls.kind = ctwl_pkg::KIND_FULL;
    end
  end

  // two-word queue towards the back end
  assign in_stall = cnt_r[1];
  assign push     = in_valid && !in_stall;
  assign q_valid  = cnt_r != 2'd0;
  assign q_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

[sv/ctwl_back.sv]
`timescale 1ns / 1ps
module ctwl_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ctwl_pkg::item_t q_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_grey_level,
  output logic [1:0]      out_status
);

  localparam int Steps = ctwl_pkg::GreyW;

  logic                         en;
  logic                         v_r    [Steps+2];
  ctwl_pkg::status_t            st_r   [Steps+2];
  ctwl_pkg::kind_t              kind_r [Steps+2];
  logic [ctwl_pkg::NumW-1:0]    rem_r  [Steps+2];
  logic [12:0]                  den_r  [Steps+2];
  logic [ctwl_pkg::GreyW-1:0]   q_r    [Steps+2];
  logic [ctwl_pkg::DiffW-1:0]   diff_r;
  logic [ctwl_pkg::DiffW-1:0]   w_r;

  assign en  = !(v_r[Steps+1] && out_stall);
  assign pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: latch operands
      st_r[0]   <= q_item.status;
      kind_r[0] <= q_item.kind;
      diff_r    <= q_item.diff;
      w_r       <= q_item.width;
      // stage 1: numerator 510*d + w, divisor 2*w
      st_r[1]   <= st_r[0];
      kind_r[1] <= kind_r[0];
      rem_r[1]  <= 22'(diff_r) * 22'(ctwl_pkg::TwiceMax) + 22'(w_r);
      den_r[1]  <= {w_r, 1'b0};
      q_r[1]    <= '0;
      // restoring division, one quotient bit per stage
      for (int i = 1; i <= Steps; i++) begin
        st_r[i+1]   <= st_r[i];
        kind_r[i+1] <= kind_r[i];
        den_r[i+1]  <= den_r[i];
        if (rem_r[i] >= (22'(den_r[i]) << (Steps - i))) begin
          rem_r[i+1] <= rem_r[i] - (22'(den_r[i]) << (Steps - i));
          q_r[i+1]   <= q_r[i] | (8'd1 << (Steps - i));
        end else begin
          rem_r[i+1] <= rem_r[i];
          q_r[i+1]   <= q_r[i];
        end
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < Steps + 2; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
      for (int i = 1; i < Steps + 2; i++) v_r[i] <= v_r[i-1];
    end
  end

  // select the result word
  always_comb begin
    case (kind_r[Steps+1])
      ctwl_pkg::KIND_FULL: out_grey_level = ctwl_pkg::GreyMax;
      ctwl_pkg::KIND_DIV:  out_grey_level = q_r[Steps+1];
      default:             out_grey_level = '0;
    endcase
  end

  assign out_valid  = v_r[Steps+1];
  assign out_status = st_r[Steps+1];

endmodule

[sv/ct_window_level_grey_map_top.sv]
`timescale 1ns / 1ps
// window/level grey mapping for CT samples
// input channel: in_valid, in_stall, in_hu_sample (13-bit two's complement HU)
// output channel: out_valid, out_stall, out_grey_level, out_status
// config channel: cfg_valid, cfg_ready (always high), cfg_index, cfg_data;
//   index 0 is window_start, index 1 is window_width, other indexes ignored
// status: 0 ok, 1 sample out of range, 2 start invalid, 3 width invalid
// one word in, one word out, in order
// throughput: one word per clock, sustained while out_stall is low
// path: an accepted word goes through the front queue, the operand latch,
//   the 510*d+w product stage and the eight-stage restoring divider
//   (one quotient bit per stage)
// a stalled output freezes the whole back pipeline; the two-word front
//   queue then fills and raises in_stall
// reset (rst_n low, synchronous) empties queue and pipeline and sets
//   window_start to -1024 and window_width to 4095
// config must be written only while no word is in flight
module ct_window_level_grey_map_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [12:0] in_hu_sample,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_grey_level,
  output logic [1:0]         out_status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);

  logic signed [12:0] start_r;
  logic [12:0]        width_r;
  logic               q_valid;
  logic               pop;
  ctwl_pkg::item_t    q_item;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= -13'sd1024;
      width_r <= 13'd4095;
    end else if (cfg_valid) begin
      if (cfg_index == ctwl_pkg::RegStart) start_r <= $signed(cfg_data);
      else if (cfg_index == ctwl_pkg::RegWidth) width_r <= cfg_data;
    end
  end

  ctwl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_hu_sample (in_hu_sample),
    .start        (start_r),
    .width        (width_r),
    .pop          (pop),
    .q_valid      (q_valid),
    .q_item       (q_item)
  );

  ctwl_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_grey_level (out_grey_level),
    .out_status     (out_status)
  );

endmodule

[tb/tb_ct_window_level_grey_map_top.sv]
`timescale 1ns / 1ps
module tb_ct_window_level_grey_map_top;

  localparam int LatencyCycles = 10;

  // expected grey/status pair for one word
  typedef struct packed {
    logic [ctwl_pkg::GreyW-1:0] grey;
    ctwl_pkg::status_t          status;
  } grey_word_t;

  // scoreboard: predicts each accepted sample and checks results in order
  class grey_scoreboard;
    grey_word_t pending_q[$];
    logic signed [ctwl_pkg::HuW-1:0] win_start;
    logic [ctwl_pkg::HuW-1:0]        win_width;
    int errors;

    function new();
      win_start = ctwl_pkg::HuMin;
      win_width = ctwl_pkg::WidthMax;
      errors = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] idx, logic [ctwl_pkg::HuW-1:0] data);
      if (idx == ctwl_pkg::RegStart) win_start = data;
      else if (idx == ctwl_pkg::RegWidth) win_width = data;
    endfunction

    function grey_word_t map_sample(logic signed [ctwl_pkg::HuW-1:0] hu);
      grey_word_t r;
      int h, s, w, d;
      h = hu;
      s = win_start;
      w = win_width;
      r.grey = '0;
      r.status = ctwl_pkg::ST_OK;
      if (h < int'(ctwl_pkg::HuMin) || h > int'(ctwl_pkg::HuMax))
        r.status = ctwl_pkg::ST_SAMPLE;
      else if (s < int'(ctwl_pkg::HuMin) || s > int'(ctwl_pkg::HuMax))
        r.status = ctwl_pkg::ST_START;
      else if (w < 1 || w > int'(ctwl_pkg::WidthMax)) r.status = ctwl_pkg::ST_WIDTH;
      else if (h < s) r.grey = 8'd0;
      else if (h > s + w) r.grey = ctwl_pkg::GreyMax;
      else begin
        d = (510 * (h - s) + w) / (2 * w);
        r.grey = (d > 255) ? ctwl_pkg::GreyMax : d[7:0];
      end
      return r;
    endfunction

    function void note_sample(logic signed [ctwl_pkg::HuW-1:0] hu);
      pending_q.push_back(map_sample(hu));
    endfunction

    task check_result(logic [7:0] grey, logic [1:0] status);
      grey_word_t e;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word grey=%0d status=%0d",
                                  grey, status));
        return;
      end
      e = pending_q.pop_front();
      if (grey !== e.grey)
        report_mismatch($sformatf("grey %0d, wanted %0d", grey, e.grey));
      if (status !== e.status)
        report_mismatch($sformatf("status %0d, wanted %0d", status, e.status));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [12:0] in_hu_sample;
  logic out_valid, out_stall;
  logic [7:0] out_grey_level;
  logic [1:0] out_status;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [12:0] cfg_data;

  grey_scoreboard sb;
  int idle_pct = 30;
  bit hold_off = 0;

  ct_window_level_grey_map_top uut (.*);

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else begin
      if (out_valid && !out_stall) sb.check_result(out_grey_level, out_status);
      out_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end
  end

  // send one word, with random idle cycles before it
  task automatic send_sample(logic signed [12:0] hu);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_hu_sample <= hu;
    do @(posedge clk); while (in_stall);
    sb.note_sample(hu);
  endtask

  // wait until every word has come back, then let the pipeline drain
  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LatencyCycles + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(logic signed [12:0] st, logic [12:0] w);
    drain();
    write_reg(ctwl_pkg::RegStart, st);
    write_reg(ctwl_pkg::RegWidth, w);
  endtask

  function automatic logic signed [12:0] pick_sample(logic signed [12:0] st,
                                                     logic [12:0] w);
    int r, v;
    r = $urandom_range(99);
    if (r < 8) return 13'($urandom);
    if (r < 60) begin
      v = int'(st) + int'($urandom_range(int'(w) + 1)) - 1;
      if (v < -1024) v = -1024;
      if (v > 3071) v = 3071;
      return 13'(v);
    end
    v = int'($urandom_range(4095));
    return 13'(v - 1024);
  endfunction

  initial begin
    logic signed [12:0] st;
    logic [12:0] w;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_hu_sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset window, field extremes, out-of-range samples
    send_sample(13'sh1000); send_sample(13'sd4095); send_sample(-13'sd1025);
    send_sample(13'sd3072); send_sample(-13'sd1024); send_sample(13'sd3071);
    send_sample(13'sd0); send_sample(-13'sd1);
    // invalid start, invalid width, sample invalid winning over both
    set_window(13'sd3072, 13'd0);
    send_sample(13'sd100); send_sample(-13'sd2000);
    set_window(13'sh1000, 13'd10);
    send_sample(13'sd100);
    set_window(13'sd0, 13'd0);
    send_sample(13'sd100); send_sample(13'sd1000);
    set_window(13'sd0, 13'd8191);
    send_sample(13'sd5);
    set_window(13'sd0, 13'd4096);
    send_sample(13'sd5);
    // narrow window: edges, tie rounding, below and above
    set_window(13'sd100, 13'd2);
    send_sample(13'sd99); send_sample(13'sd100); send_sample(13'sd101);
    send_sample(13'sd102); send_sample(13'sd103);
    set_window(13'sd3071, 13'd4095);
    send_sample(13'sd3071); send_sample(13'sd3070);
    drain();
    write_reg(2'd3, 13'd55);
    write_reg(2'd2, 13'd77);
    send_sample(13'sd3071);

    // random phases; one phase without idling, one with a long hold-off
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin st = -13'sd1024; w = 13'd1; end
        1: begin st = 13'sd3071; w = 13'd4095; end
        2: begin st = -13'sd1024; w = 13'd4095; end
        default: begin
          st = 13'(int'($urandom_range(4095)) - 1024);
          w = ($urandom_range(3) == 0) ? 13'($urandom_range(4095, 1))
                                       : 13'($urandom_range(600, 1));
          if ($urandom_range(15) == 0) st = 13'($urandom);
          if ($urandom_range(15) == 0) w = 13'($urandom);
        end
      endcase
      set_window(st, w);
      idle_pct = (ph == 4) ? 0 : 30;
      if (ph == 5) fork
        begin
          hold_off <= 1'b1;
          repeat (60) @(posedge clk);
          hold_off <= 1'b0;
        end
      join_none
      for (int k = 0; k < 95; k++) send_sample(pick_sample(st, w));
    end
    idle_pct = 30;

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
sv/ctwl_pkg.sv
sv/ctwl_front.sv
sv/ctwl_back.sv
sv/ct_window_level_grey_map_top.sv
tb/tb_ct_window_level_grey_map_top.sv
